FILE: rtl/asp_pkg.sv
// Shared constants, tables and stage types for the attitude setpoint packer.
// Used by every module under rtl/; depends on nothing else.
package asp_pkg;

  // Field widths fixed by the channel format
  localparam int STICK_W = 15;
  localparam int FLT_W   = 32;
  localparam int THR_W   = 16;

  // Stick scaling: roll/pitch = -stick * FIX_ONE / ROLL_DIV, yaw = -stick * FIX_ONE / YAW_DIV
  localparam int FIX_ONE    = 65536;
  localparam int FRAC_BITS  = 16;
  localparam int STICK_FULL = 10000;
  localparam int ROLL_DIV   = STICK_FULL / 50;
  localparam int YAW_DIV    = STICK_FULL / 400;
  // Roll/pitch reduce to a divide by YAW_DIV after scaling by RP_SCALE
  localparam int RP_SCALE   = (FIX_ONE * YAW_DIV) / ROLL_DIV;

  // Reciprocal of YAW_DIV, exact for every 15-bit magnitude
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 16;
  localparam int RECIP_DIV   = ((1 << RECIP_SHIFT) + YAW_DIV - 1) / YAW_DIV;

  // Datapath widths
  localparam int ABS_W    = STICK_W;
  localparam int Q_W      = 10;
  localparam int REM_W    = 5;
  localparam int FRAC13_W = 13;
  localparam int RP_MAG_W = Q_W + FRAC13_W;
  localparam int MAG_W    = Q_W + FRAC_BITS;
  localparam int FIX_W    = RP_MAG_W + 1;
  localparam int SUM_W    = FIX_W + 1;
  localparam int ROT_W    = RP_MAG_W;
  localparam int POS_W    = $clog2(MAG_W);
  localparam int MANT_W   = 23;
  localparam int EXP_W    = 8;

  // 45 degree rotation factor 181/256
  localparam int ROT_MUL   = 181;
  localparam int ROT_MUL_W = 8;
  localparam int ROT_SHIFT = 8;

  // Biased exponent for a leading one at bit 0 of a 16.16 magnitude
  localparam int EXP_OFS = 127 - FRAC_BITS;

  // Thrust mapping
  localparam int THR_EXT_W = 18;
  localparam logic signed [STICK_W-1:0]   THR_HI    = 15'sd10000;
  localparam logic signed [STICK_W-1:0]   THR_LO    = -15'sd10000;
  localparam logic signed [THR_EXT_W-1:0] THR_OFS   = 18'sd35535;
  localparam logic signed [THR_EXT_W-1:0] THR_FLOOR = 18'sd6000;

  // Pipeline depth: input register through output register
  localparam int NSTAGE = 7;

  // Per-stage load strobes
  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } pipe_ld_t;

  // Fixed-point values after scaling
  typedef struct packed {
    logic                    mode_neg;
    logic                    roll_neg;
    logic                    pitch_neg;
    logic                    yaw_neg;
    logic [RP_MAG_W-1:0]     roll_mag;
    logic [RP_MAG_W-1:0]     pitch_mag;
    logic [MAG_W-1:0]        yaw_mag;
    logic signed [FIX_W-1:0] roll_fix;
    logic signed [FIX_W-1:0] pitch_fix;
    logic [THR_W-1:0]        thrust;
  } fix_stage_t;

  // Sign-magnitude values ready for float conversion
  typedef struct packed {
    logic             roll_neg;
    logic             pitch_neg;
    logic             yaw_neg;
    logic [MAG_W-1:0] roll_mag;
    logic [MAG_W-1:0] pitch_mag;
    logic [MAG_W-1:0] yaw_mag;
    logic [THR_W-1:0] thrust;
  } mag_stage_t;

  // floor(r * RP_SCALE / YAW_DIV) for a remainder r below YAW_DIV
  function automatic logic [FRAC13_W-1:0] frac13(input logic [REM_W-1:0] r);
    logic [FRAC13_W-1:0] t;
    case (r)
      5'd0:    t = '0;
      5'd1:    t = FRAC13_W'((1 * RP_SCALE) / YAW_DIV);
      5'd2:    t = FRAC13_W'((2 * RP_SCALE) / YAW_DIV);
      5'd3:    t = FRAC13_W'((3 * RP_SCALE) / YAW_DIV);
      5'd4:    t = FRAC13_W'((4 * RP_SCALE) / YAW_DIV);
      5'd5:    t = FRAC13_W'((5 * RP_SCALE) / YAW_DIV);
      5'd6:    t = FRAC13_W'((6 * RP_SCALE) / YAW_DIV);
      5'd7:    t = FRAC13_W'((7 * RP_SCALE) / YAW_DIV);
      5'd8:    t = FRAC13_W'((8 * RP_SCALE) / YAW_DIV);
      5'd9:    t = FRAC13_W'((9 * RP_SCALE) / YAW_DIV);
      5'd10:   t = FRAC13_W'((10 * RP_SCALE) / YAW_DIV);
      5'd11:   t = FRAC13_W'((11 * RP_SCALE) / YAW_DIV);
      5'd12:   t = FRAC13_W'((12 * RP_SCALE) / YAW_DIV);
      5'd13:   t = FRAC13_W'((13 * RP_SCALE) / YAW_DIV);
      5'd14:   t = FRAC13_W'((14 * RP_SCALE) / YAW_DIV);
      5'd15:   t = FRAC13_W'((15 * RP_SCALE) / YAW_DIV);
      5'd16:   t = FRAC13_W'((16 * RP_SCALE) / YAW_DIV);
      5'd17:   t = FRAC13_W'((17 * RP_SCALE) / YAW_DIV);
      5'd18:   t = FRAC13_W'((18 * RP_SCALE) / YAW_DIV);
      5'd19:   t = FRAC13_W'((19 * RP_SCALE) / YAW_DIV);
      5'd20:   t = FRAC13_W'((20 * RP_SCALE) / YAW_DIV);
      5'd21:   t = FRAC13_W'((21 * RP_SCALE) / YAW_DIV);
      5'd22:   t = FRAC13_W'((22 * RP_SCALE) / YAW_DIV);
      5'd23:   t = FRAC13_W'((23 * RP_SCALE) / YAW_DIV);
      5'd24:   t = FRAC13_W'((24 * RP_SCALE) / YAW_DIV);
      default: t = '0;
    endcase
    return t;
  endfunction

  // floor(r * FIX_ONE / YAW_DIV) for a remainder r below YAW_DIV
  function automatic logic [FRAC_BITS-1:0] frac16(input logic [REM_W-1:0] r);
    logic [FRAC_BITS-1:0] t;
    case (r)
      5'd0:    t = '0;
      5'd1:    t = FRAC_BITS'((1 * FIX_ONE) / YAW_DIV);
      5'd2:    t = FRAC_BITS'((2 * FIX_ONE) / YAW_DIV);
      5'd3:    t = FRAC_BITS'((3 * FIX_ONE) / YAW_DIV);
      5'd4:    t = FRAC_BITS'((4 * FIX_ONE) / YAW_DIV);
      5'd5:    t = FRAC_BITS'((5 * FIX_ONE) / YAW_DIV);
      5'd6:    t = FRAC_BITS'((6 * FIX_ONE) / YAW_DIV);
      5'd7:    t = FRAC_BITS'((7 * FIX_ONE) / YAW_DIV);
      5'd8:    t = FRAC_BITS'((8 * FIX_ONE) / YAW_DIV);
      5'd9:    t = FRAC_BITS'((9 * FIX_ONE) / YAW_DIV);
      5'd10:   t = FRAC_BITS'((10 * FIX_ONE) / YAW_DIV);
      5'd11:   t = FRAC_BITS'((11 * FIX_ONE) / YAW_DIV);
      5'd12:   t = FRAC_BITS'((12 * FIX_ONE) / YAW_DIV);
      5'd13:   t = FRAC_BITS'((13 * FIX_ONE) / YAW_DIV);
      5'd14:   t = FRAC_BITS'((14 * FIX_ONE) / YAW_DIV);
      5'd15:   t = FRAC_BITS'((15 * FIX_ONE) / YAW_DIV);
      5'd16:   t = FRAC_BITS'((16 * FIX_ONE) / YAW_DIV);
      5'd17:   t = FRAC_BITS'((17 * FIX_ONE) / YAW_DIV);
      5'd18:   t = FRAC_BITS'((18 * FIX_ONE) / YAW_DIV);
      5'd19:   t = FRAC_BITS'((19 * FIX_ONE) / YAW_DIV);
      5'd20:   t = FRAC_BITS'((20 * FIX_ONE) / YAW_DIV);
      5'd21:   t = FRAC_BITS'((21 * FIX_ONE) / YAW_DIV);
      5'd22:   t = FRAC_BITS'((22 * FIX_ONE) / YAW_DIV);
      5'd23:   t = FRAC_BITS'((23 * FIX_ONE) / YAW_DIV);
      5'd24:   t = FRAC_BITS'((24 * FIX_ONE) / YAW_DIV);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/asp_pipe_ctrl.sv
// Valid tracking and per-stage load strobes for the setpoint pipeline.
// Depends on asp_pkg (NSTAGE, pipe_ld_t).
module asp_pipe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output asp_pkg::pipe_ld_t ld
);

  logic [asp_pkg::NSTAGE-1:0] v_r;
  logic [asp_pkg::NSTAGE-1:0] v_nxt;
  logic [asp_pkg::NSTAGE-1:0] ld_vec;
  logic [asp_pkg::NSTAGE:0]   rdy;
  logic                       in_fire;
  logic                       out_fire;

  // A stage can take a transaction when empty or when its item moves on
  always_comb begin
    rdy[asp_pkg::NSTAGE] = out_ready;
    for (int k = asp_pkg::NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  // Load strobes and next valid bits
  always_comb begin
    ld_vec[0] = in_valid && rdy[0];
    for (int k = 1; k < asp_pkg::NSTAGE; k++) begin
      ld_vec[k] = v_r[k-1] && rdy[k];
    end
    for (int k = 0; k < asp_pkg::NSTAGE; k++) begin
      v_nxt[k] = ld_vec[k] || (v_r[k] && !rdy[k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    ld.s0 = ld_vec[0];
    ld.s1 = ld_vec[1];
    ld.s2 = ld_vec[2];
    ld.s3 = ld_vec[3];
    ld.s4 = ld_vec[4];
    ld.s5 = ld_vec[5];
    ld.s6 = ld_vec[6];
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[asp_pkg::NSTAGE-1];
  assign in_fire   = in_valid && rdy[0];
  assign out_fire  = v_r[asp_pkg::NSTAGE-1] && out_ready;

  // Items in flight change only by accepted and delivered transactions
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(v_r) ==
              $past($countones(v_r)) + $past(int'(in_fire)) - $past(int'(out_fire))))
    else $error("pipeline occupancy does not match transactions");

  // A full pipeline with a stalled receiver takes nothing
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((&v_r) && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline full and stalled");

  // An accepted transaction lands in the input register
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> v_r[0])
    else $error("accepted transaction missing from input register");

  // A result appears only when the stage before it held an item
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v_r[asp_pkg::NSTAGE-1]) |-> $past(v_r[asp_pkg::NSTAGE-2]))
    else $error("result appeared without a source item");

endmodule

FILE: rtl/asp_front.sv
// Input register, stick scaling to 16.16 fixed point and thrust mapping.
// Depends on asp_pkg (constants, frac tables, pipe_ld_t, fix_stage_t).
module asp_front (
  input  logic                                clk,
  input  asp_pkg::pipe_ld_t                   ld,
  input  logic signed [asp_pkg::STICK_W-1:0]  roll_stick,
  input  logic signed [asp_pkg::STICK_W-1:0]  pitch_stick,
  input  logic signed [asp_pkg::STICK_W-1:0]  throttle_stick,
  input  logic signed [asp_pkg::STICK_W-1:0]  yaw_stick,
  input  logic signed [asp_pkg::STICK_W-1:0]  mode_switch,
  output asp_pkg::fix_stage_t                 fix_o
);

  // Exact floor(a / YAW_DIV) through the reciprocal
  function automatic logic [asp_pkg::Q_W-1:0] div_base(input logic [asp_pkg::ABS_W-1:0] a);
    logic [asp_pkg::ABS_W+asp_pkg::RECIP_W-1:0] p;
    p = (asp_pkg::ABS_W+asp_pkg::RECIP_W)'(a) *
        (asp_pkg::ABS_W+asp_pkg::RECIP_W)'(asp_pkg::RECIP_DIV);
    return p[asp_pkg::RECIP_SHIFT+asp_pkg::Q_W-1:asp_pkg::RECIP_SHIFT];
  endfunction

  // Remainder a - q * YAW_DIV, with the constant product in shifts and adds
  function automatic logic [asp_pkg::REM_W-1:0] rem_base(input logic [asp_pkg::ABS_W-1:0] a,
                                                         input logic [asp_pkg::Q_W-1:0] q);
    logic [asp_pkg::ABS_W-1:0] qx;
    logic [asp_pkg::ABS_W-1:0] d;
    qx = asp_pkg::ABS_W'(q);
    d  = a - ((qx << 4) + (qx << 3) + qx);
    return d[asp_pkg::REM_W-1:0];
  endfunction

  function automatic logic [asp_pkg::ABS_W-1:0] mag15(input logic signed [asp_pkg::STICK_W-1:0] s);
    logic [asp_pkg::ABS_W-1:0] m;
    m = s[asp_pkg::STICK_W-1] ? asp_pkg::ABS_W'(-s) : asp_pkg::ABS_W'(s);
    return m;
  endfunction

  // Stage 0: input register
  logic signed [asp_pkg::STICK_W-1:0] roll_s0_r, pitch_s0_r, thr_s0_r, yaw_s0_r, mode_s0_r;

  always_ff @(posedge clk) begin
    if (ld.s0) begin
      roll_s0_r  <= roll_stick;
      pitch_s0_r <= pitch_stick;
      thr_s0_r   <= throttle_stick;
      yaw_s0_r   <= yaw_stick;
      mode_s0_r  <= mode_switch;
    end
  end

  // Stage 1: magnitudes, quotients and thrust
  logic [asp_pkg::ABS_W-1:0]          roll_abs, pitch_abs, yaw_abs;
  logic signed [asp_pkg::STICK_W-1:0] thr_c;
  logic signed [asp_pkg::THR_EXT_W-1:0] thr_ext, thr_map;
  logic [asp_pkg::THR_W-1:0]          thrust_nxt;

  always_comb begin
    roll_abs  = mag15(roll_s0_r);
    pitch_abs = mag15(pitch_s0_r);
    yaw_abs   = mag15(yaw_s0_r);
  end

  // Clamp the throttle, map by 3x + offset, and cut below the floor
  always_comb begin
    if (thr_s0_r < asp_pkg::THR_LO) begin
      thr_c = asp_pkg::THR_LO;
    end else if (thr_s0_r > asp_pkg::THR_HI) begin
      thr_c = asp_pkg::THR_HI;
    end else begin
      thr_c = thr_s0_r;
    end
    thr_ext = {{(asp_pkg::THR_EXT_W-asp_pkg::STICK_W){thr_c[asp_pkg::STICK_W-1]}}, thr_c};
    thr_map = thr_ext + thr_ext + thr_ext + asp_pkg::THR_OFS;
    if (thr_map < asp_pkg::THR_FLOOR) begin
      thrust_nxt = '0;
    end else begin
      thrust_nxt = thr_map[asp_pkg::THR_W-1:0];
    end
  end

  logic [asp_pkg::ABS_W-1:0] roll_abs_r, pitch_abs_r, yaw_abs_r;
  logic [asp_pkg::Q_W-1:0]   roll_q_r, pitch_q_r, yaw_q_r;
  logic                      roll_neg_r, pitch_neg_r, yaw_neg_r, mode_neg_r;
  logic [asp_pkg::THR_W-1:0] thrust_s1_r;

  // Negated scale: a positive stick gives a negative value
  always_ff @(posedge clk) begin
    if (ld.s1) begin
      roll_abs_r  <= roll_abs;
      pitch_abs_r <= pitch_abs;
      yaw_abs_r   <= yaw_abs;
      roll_q_r    <= div_base(roll_abs);
      pitch_q_r   <= div_base(pitch_abs);
      yaw_q_r     <= div_base(yaw_abs);
      roll_neg_r  <= !roll_s0_r[asp_pkg::STICK_W-1];
      pitch_neg_r <= !pitch_s0_r[asp_pkg::STICK_W-1];
      yaw_neg_r   <= !yaw_s0_r[asp_pkg::STICK_W-1];
      mode_neg_r  <= mode_s0_r[asp_pkg::STICK_W-1];
      thrust_s1_r <= thrust_nxt;
    end
  end

  // Stage 2: assemble fixed-point magnitudes and signed values
  asp_pkg::fix_stage_t fix_nxt, fix_r;
  logic [asp_pkg::FIX_W-1:0] roll_ext, pitch_ext;

  always_comb begin
    fix_nxt.mode_neg  = mode_neg_r;
    fix_nxt.roll_neg  = roll_neg_r;
    fix_nxt.pitch_neg = pitch_neg_r;
    fix_nxt.yaw_neg   = yaw_neg_r;
    fix_nxt.roll_mag  = {roll_q_r, asp_pkg::frac13(rem_base(roll_abs_r, roll_q_r))};
    fix_nxt.pitch_mag = {pitch_q_r, asp_pkg::frac13(rem_base(pitch_abs_r, pitch_q_r))};
    fix_nxt.yaw_mag   = {yaw_q_r, asp_pkg::frac16(rem_base(yaw_abs_r, yaw_q_r))};
    roll_ext          = {1'b0, fix_nxt.roll_mag};
    pitch_ext         = {1'b0, fix_nxt.pitch_mag};
    fix_nxt.roll_fix  = roll_neg_r ? signed'(-roll_ext) : signed'(roll_ext);
    fix_nxt.pitch_fix = pitch_neg_r ? signed'(-pitch_ext) : signed'(pitch_ext);
    fix_nxt.thrust    = thrust_s1_r;
  end

  always_ff @(posedge clk) begin
    if (ld.s2) begin
      fix_r <= fix_nxt;
    end
  end

  assign fix_o = fix_r;

endmodule

FILE: rtl/asp_rotate.sv
// Optional 45 degree frame rotation of roll and pitch by 181/256.
// Depends on asp_pkg (fix_stage_t, mag_stage_t, widths, rotation factor).
module asp_rotate (
  input  logic                clk,
  input  asp_pkg::pipe_ld_t   ld,
  input  asp_pkg::fix_stage_t fix_i,
  output asp_pkg::mag_stage_t mag_o
);

  // Sign and truncated magnitude of s * 181 / 256
  function automatic logic [asp_pkg::ROT_W:0] rot_scale(input logic [asp_pkg::SUM_W-1:0] s);
    logic [asp_pkg::SUM_W-1:0] ns;
    logic [asp_pkg::FIX_W-1:0] a;
    logic [asp_pkg::FIX_W+asp_pkg::ROT_MUL_W-1:0] p;
    ns = -s;
    a  = s[asp_pkg::SUM_W-1] ? ns[asp_pkg::FIX_W-1:0] : s[asp_pkg::FIX_W-1:0];
    p  = (asp_pkg::FIX_W+asp_pkg::ROT_MUL_W)'(a) *
         (asp_pkg::FIX_W+asp_pkg::ROT_MUL_W)'(asp_pkg::ROT_MUL);
    return {s[asp_pkg::SUM_W-1], p[asp_pkg::ROT_SHIFT+asp_pkg::ROT_W-1:asp_pkg::ROT_SHIFT]};
  endfunction

  // Stage 3: sum and difference of the signed values
  logic signed [asp_pkg::SUM_W-1:0] sum_nxt, diff_nxt;
  logic [asp_pkg::SUM_W-1:0]        sum_r, diff_r;
  logic                             mode_neg_r, roll_neg_r, pitch_neg_r, yaw_neg_r;
  logic [asp_pkg::RP_MAG_W-1:0]     roll_mag_r, pitch_mag_r;
  logic [asp_pkg::MAG_W-1:0]        yaw_mag_r;
  logic [asp_pkg::THR_W-1:0]        thrust_r;

  always_comb begin
    sum_nxt  = asp_pkg::SUM_W'(fix_i.roll_fix) + asp_pkg::SUM_W'(fix_i.pitch_fix);
    diff_nxt = asp_pkg::SUM_W'(fix_i.pitch_fix) - asp_pkg::SUM_W'(fix_i.roll_fix);
  end

  always_ff @(posedge clk) begin
    if (ld.s3) begin
      sum_r       <= sum_nxt;
      diff_r      <= diff_nxt;
      mode_neg_r  <= fix_i.mode_neg;
      roll_neg_r  <= fix_i.roll_neg;
      pitch_neg_r <= fix_i.pitch_neg;
      yaw_neg_r   <= fix_i.yaw_neg;
      roll_mag_r  <= fix_i.roll_mag;
      pitch_mag_r <= fix_i.pitch_mag;
      yaw_mag_r   <= fix_i.yaw_mag;
      thrust_r    <= fix_i.thrust;
    end
  end

  // Stage 4: scale the rotated pair and pick the frame
  logic [asp_pkg::ROT_W:0] roll_rot, pitch_rot;
  asp_pkg::mag_stage_t     mag_nxt, mag_r;

  always_comb begin
    roll_rot  = rot_scale(sum_r);
    pitch_rot = rot_scale(diff_r);
    if (mode_neg_r) begin
      mag_nxt.roll_neg  = roll_rot[asp_pkg::ROT_W];
      mag_nxt.roll_mag  = asp_pkg::MAG_W'(roll_rot[asp_pkg::ROT_W-1:0]);
      mag_nxt.pitch_neg = pitch_rot[asp_pkg::ROT_W];
      mag_nxt.pitch_mag = asp_pkg::MAG_W'(pitch_rot[asp_pkg::ROT_W-1:0]);
    end else begin
      mag_nxt.roll_neg  = roll_neg_r;
      mag_nxt.roll_mag  = asp_pkg::MAG_W'(roll_mag_r);
      mag_nxt.pitch_neg = pitch_neg_r;
      mag_nxt.pitch_mag = asp_pkg::MAG_W'(pitch_mag_r);
    end
    mag_nxt.yaw_neg = yaw_neg_r;
    mag_nxt.yaw_mag = yaw_mag_r;
    mag_nxt.thrust  = thrust_r;
  end

  always_ff @(posedge clk) begin
    if (ld.s4) begin
      mag_r <= mag_nxt;
    end
  end

  assign mag_o = mag_r;

endmodule

FILE: rtl/asp_float_conv.sv
// Sign-magnitude 16.16 to single-precision bit patterns, mantissa truncated.
// Depends on asp_pkg (mag_stage_t, widths, exponent offset).
module asp_float_conv (
  input  logic                      clk,
  input  asp_pkg::pipe_ld_t         ld,
  input  asp_pkg::mag_stage_t       mag_i,
  output logic [asp_pkg::FLT_W-1:0] roll_float,
  output logic [asp_pkg::FLT_W-1:0] pitch_float,
  output logic [asp_pkg::FLT_W-1:0] yaw_float,
  output logic [asp_pkg::THR_W-1:0] thrust_word
);

  localparam int LANES      = 3;
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  logic [asp_pkg::MAG_W-1:0] mag_in [LANES];
  logic                      neg_in [LANES];

  always_comb begin
    mag_in[LANE_ROLL]  = mag_i.roll_mag;
    mag_in[LANE_PITCH] = mag_i.pitch_mag;
    mag_in[LANE_YAW]   = mag_i.yaw_mag;
    neg_in[LANE_ROLL]  = mag_i.roll_neg;
    neg_in[LANE_PITCH] = mag_i.pitch_neg;
    neg_in[LANE_YAW]   = mag_i.yaw_neg;
  end

  // Stage 5: find the leading one of each magnitude
  logic [asp_pkg::POS_W-1:0] pos_nxt [LANES];
  logic [asp_pkg::POS_W-1:0] pos_r   [LANES];
  logic [asp_pkg::MAG_W-1:0] mag_r   [LANES];
  logic                      neg_r   [LANES];
  logic [asp_pkg::THR_W-1:0] thrust_s5_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pos_nxt[l] = '0;
      for (int b = 0; b < asp_pkg::MAG_W; b++) begin
        if (mag_in[l][b]) begin
          pos_nxt[l] = asp_pkg::POS_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s5) begin
      for (int l = 0; l < LANES; l++) begin
        pos_r[l] <= pos_nxt[l];
        mag_r[l] <= mag_in[l];
        neg_r[l] <= neg_in[l];
      end
      thrust_s5_r <= mag_i.thrust;
    end
  end

  // Stage 6: normalize, drop the hidden one, pack sign and exponent
  logic [asp_pkg::MAG_W-1:0] norm   [LANES];
  logic [asp_pkg::EXP_W-1:0] expo   [LANES];
  logic [asp_pkg::FLT_W-1:0] flt_nxt[LANES];
  logic [asp_pkg::FLT_W-1:0] flt_r  [LANES];
  logic [asp_pkg::THR_W-1:0] thrust_r;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      norm[l] = mag_r[l] << (asp_pkg::POS_W'(asp_pkg::MAG_W - 1) - pos_r[l]);
      expo[l] = asp_pkg::EXP_W'(asp_pkg::EXP_OFS) + asp_pkg::EXP_W'(pos_r[l]);
      if (mag_r[l] == '0) begin
        flt_nxt[l] = '0;
      end else begin
        flt_nxt[l] = {neg_r[l], expo[l], norm[l][asp_pkg::MAG_W-2 -: asp_pkg::MANT_W]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.s6) begin
      for (int l = 0; l < LANES; l++) begin
        flt_r[l] <= flt_nxt[l];
      end
      thrust_r <= thrust_s5_r;
    end
  end

  assign roll_float  = flt_r[LANE_ROLL];
  assign pitch_float = flt_r[LANE_PITCH];
  assign yaw_float   = flt_r[LANE_YAW];
  assign thrust_word = thrust_r;

endmodule

FILE: rtl/attitude_setpoint_packer_top.sv
// Top level of the attitude setpoint packer: stick channels in, setpoint out.
// Depends on asp_pkg, asp_pipe_ctrl, asp_front, asp_rotate and asp_float_conv.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction of four stick
//   values and a mode switch, each 15-bit two's complement. Output channel
//   (out_valid/out_ready) returns one setpoint per input: roll, pitch and yaw
//   as single-precision bit patterns and a 16-bit thrust word.
//   Throughput: one transaction per cycle while out_ready is high; the
//   seven-register pipeline (input register, five datapath stages, output
//   register) is fully overlapped; the divide is a 15x16 reciprocal multiply.
//   Reset: rst_n is synchronous and active low; it empties the pipeline and
//   drops any transaction in flight. No clearing pass is needed.
//   Stall: when out_ready is low the held result stays on the output ports;
//   the stages behind it keep filling, and in_ready falls only once every
//   stage holds a transaction.
module attitude_setpoint_packer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [asp_pkg::STICK_W-1:0] in_roll_stick,
  input  logic signed [asp_pkg::STICK_W-1:0] in_pitch_stick,
  input  logic signed [asp_pkg::STICK_W-1:0] in_throttle_stick,
  input  logic signed [asp_pkg::STICK_W-1:0] in_yaw_stick,
  input  logic signed [asp_pkg::STICK_W-1:0] in_mode_switch,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [asp_pkg::FLT_W-1:0]          out_roll_float,
  output logic [asp_pkg::FLT_W-1:0]          out_pitch_float,
  output logic [asp_pkg::FLT_W-1:0]          out_yaw_float,
  output logic [asp_pkg::THR_W-1:0]          out_thrust_word
);

  asp_pkg::pipe_ld_t   ld;
  asp_pkg::fix_stage_t fix_s;
  asp_pkg::mag_stage_t mag_s;

  // Handshake and stage enables
  asp_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ld        (ld)
  );

  // Scale sticks and map thrust
  asp_front u_front (
    .clk            (clk),
    .ld             (ld),
    .roll_stick     (in_roll_stick),
    .pitch_stick    (in_pitch_stick),
    .throttle_stick (in_throttle_stick),
    .yaw_stick      (in_yaw_stick),
    .mode_switch    (in_mode_switch),
    .fix_o          (fix_s)
  );

  // Select plain or rotated frame
  asp_rotate u_rotate (
    .clk   (clk),
    .ld    (ld),
    .fix_i (fix_s),
    .mag_o (mag_s)
  );

  // Convert to float patterns and drive the result register
  asp_float_conv u_conv (
    .clk         (clk),
    .ld          (ld),
    .mag_i       (mag_s),
    .roll_float  (out_roll_float),
    .pitch_float (out_pitch_float),
    .yaw_float   (out_yaw_float),
    .thrust_word (out_thrust_word)
  );

endmodule

FILE: verif/tb_attitude_setpoint_packer_top.sv
// Testbench for attitude_setpoint_packer_top: directed and random stick sets with random idling.
// A scoreboard class predicts each setpoint and compares the results in order.
// Depends on asp_pkg and the RTL under rtl/.
module tb_attitude_setpoint_packer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import asp_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 500;
  localparam int MAX_IDLE      = 17;
  localparam int SETTLE_CYCLES = 20;

  typedef logic signed [STICK_W-1:0] stick_t;

  typedef struct {
    stick_t roll;
    stick_t pitch;
    stick_t throttle;
    stick_t yaw;
    stick_t mode;
  } stick_set_t;

  typedef struct {
    logic [FLT_W-1:0] roll;
    logic [FLT_W-1:0] pitch;
    logic [FLT_W-1:0] yaw;
    logic [THR_W-1:0] thrust;
  } setpoint_t;

  // Predict setpoints for accepted stick sets and check results in order
  class setpoint_scoreboard;
    setpoint_t   expected_setpoints[$];
    int unsigned mismatches = 0;

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Signed 16.16 value to a single-precision pattern, mantissa truncated
    function logic [FLT_W-1:0] to_single_bits(longint fixv);
      logic [31:0]      mag;
      logic [FLT_W-1:0] bits;
      int               expo;
      if (fixv == 0) return '0;
      mag  = (fixv < 0) ? 32'(-fixv) : 32'(fixv);
      expo = 31 - FRAC_BITS;
      // Shift up to the leading one
      while (!mag[31]) begin
        mag = mag << 1;
        expo--;
      end
      mag  = mag << 1;
      bits = mag >> 9;
      bits = bits | (32'(8'(127 + expo)) << MANT_W);
      bits[FLT_W-1] = (fixv < 0);
      return bits;
    endfunction

    function setpoint_t predict_setpoint(stick_set_t s);
      setpoint_t sp;
      longint    fix_roll, fix_pitch, fix_yaw, thr, mapped;
      fix_roll  = (-longint'(s.roll) * FIX_ONE) / ROLL_DIV;
      fix_pitch = (-longint'(s.pitch) * FIX_ONE) / ROLL_DIV;
      fix_yaw   = (-longint'(s.yaw) * FIX_ONE) / YAW_DIV;
      // Plain frame, or turn roll and pitch by 45 degrees
      if (s.mode >= 0) begin
        sp.roll  = to_single_bits(fix_roll);
        sp.pitch = to_single_bits(fix_pitch);
      end else begin
        sp.roll  = to_single_bits(((fix_roll + fix_pitch) * ROT_MUL) / (1 << ROT_SHIFT));
        sp.pitch = to_single_bits(((fix_pitch - fix_roll) * ROT_MUL) / (1 << ROT_SHIFT));
      end
      sp.yaw = to_single_bits(fix_yaw);
      // Clamp throttle, map it, and cut low thrust to zero
      thr = longint'(s.throttle);
      if (thr < -STICK_FULL) thr = -STICK_FULL;
      if (thr > STICK_FULL) thr = STICK_FULL;
      mapped = thr * 3 + 35535;
      if (mapped < 6000) mapped = 0;
      sp.thrust = THR_W'(mapped);
      return sp;
    endfunction

    function void note_sticks(stick_set_t s);
      expected_setpoints.push_back(predict_setpoint(s));
    endfunction

    task check_setpoint(setpoint_t got);
      setpoint_t exp_sp;
      if (expected_setpoints.size() == 0) begin
        report($sformatf("setpoint with none pending: roll %h pitch %h yaw %h thrust %h",
                         got.roll, got.pitch, got.yaw, got.thrust));
        return;
      end
      exp_sp = expected_setpoints.pop_front();
      if (got.roll !== exp_sp.roll)
        report($sformatf("roll_float got %h expected %h", got.roll, exp_sp.roll));
      if (got.pitch !== exp_sp.pitch)
        report($sformatf("pitch_float got %h expected %h", got.pitch, exp_sp.pitch));
      if (got.yaw !== exp_sp.yaw)
        report($sformatf("yaw_float got %h expected %h", got.yaw, exp_sp.yaw));
      if (got.thrust !== exp_sp.thrust)
        report($sformatf("thrust_word got %h expected %h", got.thrust, exp_sp.thrust));
    endtask

    function int pending();
      return expected_setpoints.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  stick_t           in_roll_stick, in_pitch_stick, in_throttle_stick;
  stick_t           in_yaw_stick, in_mode_switch;
  logic             out_valid;
  logic             out_ready;
  logic [FLT_W-1:0] out_roll_float, out_pitch_float, out_yaw_float;
  logic [THR_W-1:0] out_thrust_word;

  setpoint_scoreboard sb = new();
  int unsigned        cycle_count = 0;
  bit                 send_burst = 1'b0;
  bit                 recv_burst = 1'b0;
  int unsigned        sent_count = 0;
  int unsigned        recv_count = 0;

  attitude_setpoint_packer_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_roll_stick     (in_roll_stick),
    .in_pitch_stick    (in_pitch_stick),
    .in_throttle_stick (in_throttle_stick),
    .in_yaw_stick      (in_yaw_stick),
    .in_mode_switch    (in_mode_switch),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_roll_float    (out_roll_float),
    .out_pitch_float   (out_pitch_float),
    .out_yaw_float     (out_yaw_float),
    .out_thrust_word   (out_thrust_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watch both channels and feed the scoreboard at each rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_sticks('{in_roll_stick, in_pitch_stick, in_throttle_stick,
                         in_yaw_stick, in_mode_switch});
      if (out_valid && out_ready)
        sb.check_setpoint('{out_roll_float, out_pitch_float, out_yaw_float,
                            out_thrust_word});
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int draw_idle(bit burst);
    return burst ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Mostly nominal travel, some full range, tiny values and extremes
  function automatic stick_t rand_stick();
    case ($urandom_range(0, 9))
      0:       return stick_t'($urandom_range(0, (1 << STICK_W) - 1));
      1:       return stick_t'(int'($urandom_range(0, 16)) - 8);
      2:       return $urandom_range(0, 1) ? stick_t'(16383) : stick_t'(-16384);
      default: return stick_t'(int'($urandom_range(0, 20000)) - STICK_FULL);
    endcase
  endfunction

  // Present one transaction after a random gap; return at the falling edge after acceptance
  task automatic send_setpoint(stick_t roll, stick_t pitch, stick_t thr, stick_t yaw,
                               stick_t mode);
    int gap;
    gap = draw_idle(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_roll_stick     <= roll;
    in_pitch_stick    <= pitch;
    in_throttle_stick <= thr;
    in_yaw_stick      <= yaw;
    in_mode_switch    <= mode;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_count++;
    if (sent_count % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
  endtask

  // Hold off the sender until every pending setpoint has come back
  task automatic drain_pending();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Result side: stall at random, with stretches of no stall
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = draw_idle(recv_burst);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      recv_count++;
      if (recv_count % 40 == 0) recv_burst = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    stick_t r;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_roll_stick     = '0;
    in_pitch_stick    = '0;
    in_throttle_stick = '0;
    in_yaw_stick      = '0;
    in_mode_switch    = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero, field extremes, nominal limits, both frames
    send_setpoint(0, 0, 0, 0, 0);
    send_setpoint(16383, 16383, 16383, 16383, 16383);
    send_setpoint(-16384, -16384, -16384, -16384, -16384);
    send_setpoint(16383, -16384, 0, -16384, -1);
    send_setpoint(-16384, 16383, 0, 16383, -16384);
    send_setpoint(10000, -10000, 10000, 10000, 0);
    send_setpoint(-10000, 10000, -10000, -10000, -1);
    // Smallest magnitudes, positive and negative
    send_setpoint(1, -1, 1, 1, 0);
    send_setpoint(-1, 1, -1, -1, 0);
    send_setpoint(1, 1, 0, -1, -1);
    // Rotated frame where one axis cancels to zero
    send_setpoint(5000, 5000, 0, 0, -1);
    send_setpoint(-7000, 7000, 0, 0, -16384);
    send_setpoint(3, -3, 0, 0, -1);
    // Thrust clamp edges and the low-thrust cutoff
    send_setpoint(0, 0, 10001, 0, 0);
    send_setpoint(0, 0, -10001, 0, 0);
    send_setpoint(0, 0, -9845, 0, 0);
    send_setpoint(0, 0, -9846, 0, 0);
    send_setpoint(0, 0, 9999, 0, 0);
    send_setpoint(200, -400, 1, 25, 1);
    send_setpoint(-199, 401, -1, -26, 16383);
    drain_pending();

    // Random: mostly nominal values, both frames, some cancelling pairs
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = rand_stick();
      case ($urandom_range(0, 9))
        0:       send_setpoint(r, r, rand_stick(), rand_stick(), rand_stick());
        1:       send_setpoint(r, -r, rand_stick(), rand_stick(), rand_stick());
        default: send_setpoint(r, rand_stick(), rand_stick(), rand_stick(), rand_stick());
      endcase
      if (i == RANDOM_ITEMS / 2) drain_pending();
    end

    // Wait for the last setpoints, then wait on for any strays
    drain_pending();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
